### sv/bmp_pkg.sv
// Shared types, constants and codes for the BMP pixel stream decoder.
package bmp_pkg;

    // Default image size limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Header layout.
    localparam int HEADER_BYTES = 54;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    localparam logic [HDR_IDX_W-1:0] HDR_LAST       = HDR_IDX_W'(HEADER_BYTES - 1);
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC0_OFS = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC1_OFS = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HDR_WIDTH_OFS  = HDR_IDX_W'(8'h12);
    localparam logic [HDR_IDX_W-1:0] HDR_HEIGHT_OFS = HDR_IDX_W'(8'h16);
    localparam logic [HDR_IDX_W-1:0] HDR_BPP_OFS    = HDR_IDX_W'(8'h1C);

    localparam logic [7:0] MAGIC0 = 8'h42;
    localparam logic [7:0] MAGIC1 = 8'h4D;

    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    // Configuration port.
    localparam int ORIGIN_W    = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = ORIGIN_W;

    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = ORIGIN_W'(100);
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = ORIGIN_W'(15);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_PAD    = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL       = 2'd0,
        KIND_NOT_BMP     = 2'd1,
        KIND_UNSUPPORTED = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_start;
    } in_word_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [11:0]  pixel_x;
        logic [11:0]  pixel_y;
        logic [31:0]  pixel_color;
    } out_word_t;

endpackage

### sv/bmp_pixel_stream_decoder_core.sv
// Top level of the BMP pixel stream decoder: input, origin, parser and result registers.
//
// The decoder takes a BMP file as a stream of bytes, one byte per word, and emits one result
// word per completed pixel of a 24 or 32 bit-per-pixel image, carrying its screen coordinate
// (origin plus column index, origin plus row index counted from the top row) and its color
// as A<<24 | R<<16 | G<<8 | B, with alpha zero for 24-bit images. A word with file_start set
// restarts the parse at header byte zero; without it, the stream after reset is parsed as a
// file. A bad "BM" magic yields one not-a-BMP result, and a depth other than 24 or 32 or a size
// beyond MAX_WIDTH by MAX_HEIGHT yields one unsupported result; after either, and after the
// last byte of the top row, bytes are ignored until the next file_start. The block takes
// one byte every clock cycle while the result register is free or being emptied. Each byte
// is held in the input register, and the single state update of the parser that processes
// it writes the result register. A byte waits in the input register only while the result
// register holds a word that the consumer has not taken.
// Origin registers are written through the cfg port and should change only while no file is
// being decoded.
module bmp_pixel_stream_decoder_core #(
    parameter int MAX_WIDTH  = bmp_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp_pkg::MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bmp_pkg::in_word_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bmp_pkg::out_word_t              m_data,
    input  logic                            cfg_we,
    input  logic [bmp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                         in_valid_reg, in_valid_next;
    bmp_pkg::in_word_t            in_data_reg;
    logic [bmp_pkg::ORIGIN_W-1:0] origin_x_reg, origin_x_next;
    logic [bmp_pkg::ORIGIN_W-1:0] origin_y_reg, origin_y_next;

    logic               in_fire;
    logic               step;
    logic               res_valid;
    bmp_pkg::out_word_t res_word;

    // The held byte is processed whenever the result register is free or being emptied.
    assign step    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_data_reg <= s_data;
        end
    end

    // Origin registers; an index outside the register list changes nothing.
    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        if (cfg_we) begin
            case (cfg_index)
                bmp_pkg::REG_ORIGIN_X: origin_x_next = cfg_wdata;
                bmp_pkg::REG_ORIGIN_Y: origin_y_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= bmp_pkg::ORIGIN_X_RESET;
            origin_y_reg <= bmp_pkg::ORIGIN_Y_RESET;
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    bmp_parse #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_word  (in_data_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .res_valid(res_valid),
        .res_word (res_word)
    );

    bmp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .load_word(res_word),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

endmodule

### sv/bmp_parse.sv
// Header parser and pixel assembler: one byte of state update per step.
module bmp_parse #(
    parameter int MAX_WIDTH  = bmp_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp_pkg::MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  bmp_pkg::in_word_t            in_word,
    input  logic [bmp_pkg::ORIGIN_W-1:0] origin_x,
    input  logic [bmp_pkg::ORIGIN_W-1:0] origin_y,
    output logic                         res_valid,
    output bmp_pkg::out_word_t           res_word
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IW = bmp_pkg::HDR_IDX_W;

    bmp_pkg::phase_t phase_reg, phase_next;
    logic [IW-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [31:0]     width_reg, width_next;
    logic [31:0]     height_reg, height_next;
    logic [15:0]     bpp_reg, bpp_next;
    logic            bad0_reg, bad0_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [1:0]      pos_reg, pos_next;
    logic [23:0]     partial_reg, partial_next;
    logic [1:0]      pad_reg, pad_next;

    bmp_pkg::phase_t ph;
    logic [IW-1:0]   idx;
    logic [IW-1:0]   ofs;
    logic [7:0]      b;
    logic            bad_eff;
    logic            last_byte;
    logic [23:0]     partial_new;
    logic [7:0]      alpha;
    logic [CW:0]     col_inc;
    logic            do_next_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bmp_pkg::PH_HEADER;
            hdr_idx_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            bad0_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            pos_reg     <= '0;
            partial_reg <= '0;
            pad_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            bad0_reg    <= bad0_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
            pad_reg     <= pad_next;
        end
    end

    always_comb begin
        // A start mark restarts the parse at header byte zero.
        ph  = in_word.file_start ? bmp_pkg::PH_HEADER : phase_reg;
        idx = in_word.file_start ? '0 : hdr_idx_reg;
        b   = in_word.file_byte;
        ofs = '0;

        bad_eff     = (idx == bmp_pkg::HDR_MAGIC0_OFS) ? (b != bmp_pkg::MAGIC0) : bad0_reg;
        last_byte   = 1'b0;
        partial_new = partial_reg;
        alpha       = '0;
        col_inc     = {1'b0, col_reg} + (CW+1)'(1);
        do_next_row = 1'b0;

        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        bad0_next    = bad0_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pos_next     = pos_reg;
        partial_next = partial_reg;
        pad_next     = pad_reg;

        res_valid = 1'b0;
        res_word  = '0;

        if (step) begin
            phase_next   = ph;
            hdr_idx_next = idx;
            case (ph)
                bmp_pkg::PH_HEADER: begin
                    if (idx == bmp_pkg::HDR_MAGIC0_OFS) begin
                        bad0_next = bad_eff;
                    end
                    // Each size byte is written once per parse, least significant first.
                    if (idx inside {[bmp_pkg::HDR_WIDTH_OFS:bmp_pkg::HDR_WIDTH_OFS + 3]}) begin
                        ofs = idx - bmp_pkg::HDR_WIDTH_OFS;
                        width_next[{ofs[1:0], 3'b000} +: 8] = b;
                    end
                    if (idx inside {[bmp_pkg::HDR_HEIGHT_OFS:bmp_pkg::HDR_HEIGHT_OFS + 3]}) begin
                        ofs = idx - bmp_pkg::HDR_HEIGHT_OFS;
                        height_next[{ofs[1:0], 3'b000} +: 8] = b;
                    end
                    if (idx inside {[bmp_pkg::HDR_BPP_OFS:bmp_pkg::HDR_BPP_OFS + 1]}) begin
                        ofs = idx - bmp_pkg::HDR_BPP_OFS;
                        bpp_next[{ofs[0], 3'b000} +: 8] = b;
                    end
                    last_byte = (idx == bmp_pkg::HDR_LAST);

                    if (idx == bmp_pkg::HDR_MAGIC1_OFS && (bad_eff || b != bmp_pkg::MAGIC1)) begin
                        phase_next           = bmp_pkg::PH_IDLE;
                        res_valid            = 1'b1;
                        res_word.result_kind = bmp_pkg::KIND_NOT_BMP;
                    end else if (!last_byte) begin
                        hdr_idx_next = idx + IW'(1);
                    end else if ((bpp_reg != bmp_pkg::BPP_24 && bpp_reg != bmp_pkg::BPP_32)
                                 || width_reg > 32'(MAX_WIDTH)
                                 || height_reg > 32'(MAX_HEIGHT)) begin
                        phase_next           = bmp_pkg::PH_IDLE;
                        res_valid            = 1'b1;
                        res_word.result_kind = bmp_pkg::KIND_UNSUPPORTED;
                    end else if (width_reg == '0 || height_reg == '0) begin
                        phase_next = bmp_pkg::PH_IDLE;
                    end else begin
                        phase_next   = bmp_pkg::PH_PIXEL;
                        row_next     = RW'(height_reg - 32'd1);
                        col_next     = '0;
                        pos_next     = '0;
                        partial_next = '0;
                    end
                end

                bmp_pkg::PH_PIXEL: begin
                    if (pos_reg == 2'd3) begin
                        alpha = b;
                    end else begin
                        partial_new[{pos_reg, 3'b000} +: 8] = b;
                    end
                    if ((bpp_reg == bmp_pkg::BPP_32) ? (pos_reg != 2'd3) : (pos_reg != 2'd2)) begin
                        pos_next     = pos_reg + 2'd1;
                        partial_next = partial_new;
                    end else begin
                        res_valid            = 1'b1;
                        res_word.result_kind = bmp_pkg::KIND_PIXEL;
                        res_word.pixel_x     = {1'b0, origin_x} + 12'(col_reg);
                        res_word.pixel_y     = {1'b0, origin_y} + 12'(row_reg);
                        res_word.pixel_color = {alpha, partial_new};
                        pos_next             = '0;
                        partial_next         = '0;
                        if (32'(col_inc) >= width_reg) begin
                            // 24-bit rows pad to four bytes: pad count is width mod 4.
                            if (bpp_reg != bmp_pkg::BPP_32 && width_reg[1:0] != 2'd0) begin
                                pad_next   = width_reg[1:0];
                                phase_next = bmp_pkg::PH_PAD;
                            end else begin
                                do_next_row = 1'b1;
                            end
                        end else begin
                            col_next = col_inc[CW-1:0];
                        end
                    end
                end

                bmp_pkg::PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1) begin
                        do_next_row = 1'b1;
                    end
                end

                default: begin
                end
            endcase

            if (do_next_row) begin
                if (row_reg == '0) begin
                    phase_next = bmp_pkg::PH_IDLE;
                end else begin
                    row_next   = row_reg - RW'(1);
                    col_next   = '0;
                    phase_next = bmp_pkg::PH_PIXEL;
                end
            end
        end
    end

endmodule

### sv/bmp_out_stage.sv
// Result register with valid/ready handshake toward the consumer.
module bmp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bmp_pkg::out_word_t load_word,
    input  logic               m_ready,
    output logic               m_valid,
    output bmp_pkg::out_word_t m_data
);

    logic               valid_reg, valid_next;
    bmp_pkg::out_word_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

### sv/bmp_checker.sv
// Port-level checker for the BMP pixel stream decoder, bound to the top level.
module bmp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bmp_pkg::out_word_t m_data
);

    // A word that is not taken stays with the same contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed or dropped while stalled");

    // Error results carry no coordinate and no color.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind != bmp_pkg::KIND_PIXEL |->
            m_data.pixel_x == '0 && m_data.pixel_y == '0 && m_data.pixel_color == '0)
        else $error("error result with nonzero fields");

    // A consumer that is ready never stalls the byte stream.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output was ready");

    // A new result word must trace back to an accepted input byte.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a recent input byte");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bmp_pixel_stream_decoder_core bmp_checker u_bmp_checker (.*);

### test/bmp_decoder_checker.sv
// Checker for the BMP pixel stream decoder: predicts each result word and compares it.
module bmp_decoder_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  bmp_pkg::in_word_t               s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  bmp_pkg::out_word_t              m_data,
    input  logic                            cfg_we,
    input  logic [bmp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              error_count,
    output int                              results_due
);
    import bmp_pkg::*;

    logic [ORIGIN_W-1:0]  org_x;
    logic [ORIGIN_W-1:0]  org_y;
    phase_t               parse_ph;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [31:0]          img_w;
    logic [31:0]          img_h;
    logic [15:0]          img_bpp;
    logic [10:0]          col;
    logic [10:0]          row;
    logic [1:0]           byte_pos;
    logic [1:0]           pad_left;
    logic [23:0]          bgr_acc;
    logic                 magic0_bad;
    out_word_t            due_words[$];
    int                   mismatches = 0;

    task automatic restart_file();
        parse_ph   = PH_HEADER;
        hdr_idx    = '0;
        img_w      = '0;
        img_h      = '0;
        img_bpp    = '0;
        col        = '0;
        row        = '0;
        byte_pos   = '0;
        bgr_acc    = '0;
        pad_left   = '0;
        magic0_bad = 1'b0;
    endtask

    // Rows arrive bottom-up, so the row index counts down to zero.
    task automatic step_up_row();
        if (row == 0) begin
            parse_ph = PH_IDLE;
        end else begin
            row      = row - 1'b1;
            col      = '0;
            parse_ph = PH_PIXEL;
        end
    endtask

    task automatic decode_byte(input in_word_t w, output logic produced, output out_word_t pix);
        logic [7:0]  b;
        logic [7:0]  alpha;
        logic [1:0]  pad;
        int          idx;
        int          nbytes;
        b        = w.file_byte;
        alpha    = '0;
        produced = 1'b0;
        pix      = '0;
        if (w.file_start) begin
            restart_file();
        end
        case (parse_ph)
            PH_HEADER: begin
                idx = int'(hdr_idx);
                if (idx == int'(HDR_MAGIC0_OFS)) begin
                    magic0_bad = (b != MAGIC0);
                end
                if (idx >= int'(HDR_WIDTH_OFS) && idx < int'(HDR_WIDTH_OFS) + 4) begin
                    img_w = img_w | (32'(b) << (8 * (idx - int'(HDR_WIDTH_OFS))));
                end
                if (idx >= int'(HDR_HEIGHT_OFS) && idx < int'(HDR_HEIGHT_OFS) + 4) begin
                    img_h = img_h | (32'(b) << (8 * (idx - int'(HDR_HEIGHT_OFS))));
                end
                if (idx >= int'(HDR_BPP_OFS) && idx < int'(HDR_BPP_OFS) + 2) begin
                    img_bpp = img_bpp | (16'(b) << (8 * (idx - int'(HDR_BPP_OFS))));
                end
                if (idx == int'(HDR_MAGIC1_OFS) && (magic0_bad || b != MAGIC1)) begin
                    parse_ph        = PH_IDLE;
                    produced        = 1'b1;
                    pix.result_kind = KIND_NOT_BMP;
                end else if (idx < int'(HDR_LAST)) begin
                    hdr_idx = hdr_idx + 1'b1;
                end else if ((img_bpp != BPP_24 && img_bpp != BPP_32) ||
                             img_w > MAX_WIDTH || img_h > MAX_HEIGHT) begin
                    parse_ph        = PH_IDLE;
                    produced        = 1'b1;
                    pix.result_kind = KIND_UNSUPPORTED;
                end else if (img_w == 0 || img_h == 0) begin
                    parse_ph = PH_IDLE;
                end else begin
                    parse_ph = PH_PIXEL;
                    row      = 11'(img_h - 1);
                    col      = '0;
                    byte_pos = '0;
                    bgr_acc  = '0;
                end
            end
            PH_PIXEL: begin
                nbytes = (img_bpp == BPP_32) ? 4 : 3;
                if (byte_pos < 3) begin
                    bgr_acc = bgr_acc | (24'(b) << (8 * byte_pos));
                end else begin
                    alpha = b;
                end
                if (byte_pos + 1 < nbytes) begin
                    byte_pos = byte_pos + 1'b1;
                end else begin
                    produced        = 1'b1;
                    pix.result_kind = KIND_PIXEL;
                    pix.pixel_x     = 12'(org_x) + 12'(col);
                    pix.pixel_y     = 12'(org_y) + 12'(row);
                    pix.pixel_color = {alpha, bgr_acc};
                    byte_pos        = '0;
                    bgr_acc         = '0;
                    if (32'(col) + 1 >= img_w) begin
                        // 24-bit rows are padded to a multiple of four bytes.
                        pad = (nbytes == 3) ? 2'((4 - ((3 * int'(img_w[1:0])) % 4)) % 4) : 2'd0;
                        if (pad != 0) begin
                            pad_left = pad;
                            parse_ph = PH_PAD;
                        end else begin
                            step_up_row();
                        end
                    end else begin
                        col = col + 1'b1;
                    end
                end
            end
            PH_PAD: begin
                pad_left = pad_left - 1'b1;
                if (pad_left == 0) begin
                    step_up_row();
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        logic      produced;
        out_word_t predicted;
        out_word_t oldest;
        if (!aresetn) begin
            org_x = ORIGIN_X_RESET;
            org_y = ORIGIN_Y_RESET;
            restart_file();
            due_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X: org_x = cfg_wdata;
                    REG_ORIGIN_Y: org_y = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data, produced, predicted);
                if (produced) begin
                    due_words.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    oldest = due_words.pop_front();
                    compare_field("result_kind", 32'(oldest.result_kind),
                                  32'(m_data.result_kind));
                    compare_field("pixel_x", 32'(oldest.pixel_x), 32'(m_data.pixel_x));
                    compare_field("pixel_y", 32'(oldest.pixel_y), 32'(m_data.pixel_y));
                    compare_field("pixel_color", oldest.pixel_color, m_data.pixel_color);
                end
            end
        end
        error_count <= mismatches;
        results_due <= due_words.size();
    end

endmodule

### test/tb.sv
// Testbench top for the BMP pixel stream decoder: byte stream stimulus and final verdict.
module tb;
    import bmp_pkg::*;

    // Generous cycle budget.
    localparam int MAX_CYCLES  = 200_000;
    // Cycles allowed after the last expected result for bytes still inside the block
    // (input register plus one parser update), with some margin.
    localparam int HOLD_OFF    = 8;
    // Counted bytes in each random phase; together with the directed cases the run
    // sends about 650 bytes.
    localparam int PHASE_BYTES = 30;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int error_count;
    int results_due;
    int cycle_count     = 0;
    int fed_bytes       = 0;
    int send_gap_pct    = 0;
    int ready_stall_pct = 0;
    bit pressure_done   = 1'b0;

    bmp_pixel_stream_decoder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The checker sits beside the block, predicting every result word from the words it
    // sees accepted and comparing them with the words the block hands out.
    bmp_decoder_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .results_due (results_due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // A hung handshake must not stall the run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver stalls at random, decided fresh on every clock edge.
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= ready_stall_pct);
    end

    task automatic set_idling(input int gap_pct, input int stall_pct);
        send_gap_pct    = gap_pct;
        ready_stall_pct = stall_pct;
    endtask

    // Offers one byte and returns at the edge that accepts it. The valid line is only
    // dropped when a random gap is taken, so back-to-back words keep it high.
    task automatic send_word(input logic [7:0] b, input logic start, input bit counted);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.file_byte  <= b;
        s_data.file_start <= start;
        do @(posedge aclk); while (!s_ready);
        if (counted) begin
            fed_bytes++;
        end
    endtask

    // Stops sending and waits until every predicted result has come out, then lets the
    // block finish any trailing header or pad bytes that produce nothing.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    // Both origin registers are written on consecutive edges with the enable held high.
    task automatic set_origins(input logic [ORIGIN_W-1:0] x, input logic [ORIGIN_W-1:0] y);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORIGIN_X;
        cfg_wdata <= x;
        @(posedge aclk);
        cfg_index <= REG_ORIGIN_Y;
        cfg_wdata <= y;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Pixel bytes lean toward the extremes now and then.
    function automatic logic [7:0] pixel_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Bytes of pixel data, pad included, for a whole image.
    function automatic int image_bytes(input int w, input int h, input logic [15:0] bpp);
        int row_bytes;
        row_bytes = w * ((bpp == BPP_32) ? 4 : 3);
        return h * ((row_bytes + 3) / 4 * 4);
    endfunction

    // Sends the first cut bytes of a valid-magic header; the bytes that the decoder does
    // not interpret carry random values.
    task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                               input logic [15:0] bpp, input logic start, input int cut);
        logic [7:0] hb [HEADER_BYTES];
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hb[i] = 8'($urandom);
        end
        hb[int'(HDR_MAGIC0_OFS)] = MAGIC0;
        hb[int'(HDR_MAGIC1_OFS)] = MAGIC1;
        for (int k = 0; k < 4; k++) begin
            hb[int'(HDR_WIDTH_OFS) + k]  = w[8*k +: 8];
            hb[int'(HDR_HEIGHT_OFS) + k] = h[8*k +: 8];
        end
        hb[int'(HDR_BPP_OFS)]     = bpp[7:0];
        hb[int'(HDR_BPP_OFS) + 1] = bpp[15:8];
        for (int i = 0; i < cut; i++) begin
            send_word(hb[i], start && (i == 0), 1'b1);
        end
    endtask

    // Sends count pixel-data bytes. At byte pause_at the sender holds off until the
    // block has delivered everything it owes.
    task automatic send_pixels(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                wait_drained();
            end
            send_word(pixel_byte(), 1'b0, 1'b1);
        end
    endtask

    task automatic send_image(input logic [31:0] w, input logic [31:0] h,
                              input logic [15:0] bpp, input logic start, input int pause_at);
        send_header(w, h, bpp, start, HEADER_BYTES);
        send_pixels(image_bytes(w, h, bpp), pause_at);
    endtask

    // Bytes after an error or a finished image; the block must ignore them.
    task automatic send_junk(input int n);
        repeat (n) send_word(8'($urandom), 1'b0, 1'b0);
    endtask

    // Mostly well-formed small images with random content; the rest are cut-off files,
    // bad magic, unsupported headers, empty images, huge images cut short and noise.
    task automatic run_random(input int target);
        int          first_count;
        int          pick;
        int          body;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        logic [7:0]  b0;
        logic [7:0]  b1;
        first_count = fed_bytes;
        while (fed_bytes - first_count < target) begin
            pick = $urandom_range(99);
            w    = $urandom_range(1, 8);
            h    = $urandom_range(1, 4);
            bpp  = $urandom_range(1) ? BPP_32 : BPP_24;
            body = image_bytes(w, h, bpp);
            if (pick < 64) begin
                // Only the first well-formed random image of the whole test pauses halfway through its pixels.
                send_image(w, h, bpp, 1'b1, pressure_done ? -1 : body / 2);
                pressure_done = 1'b1;
            end else if (pick < 72) begin
                // A file cut short; the start mark of the next file drops it.
                if ($urandom_range(1)) begin
                    send_header(w, h, bpp, 1'b1, $urandom_range(1, HEADER_BYTES - 1));
                end else begin
                    send_header(w, h, bpp, 1'b1, HEADER_BYTES);
                    send_pixels($urandom_range(1, body - 1), -1);
                end
            end else if (pick < 80) begin
                // At least one of the two magic bytes is wrong.
                if ($urandom_range(1)) begin
                    do b0 = 8'($urandom); while (b0 == MAGIC0);
                    b1 = $urandom_range(1) ? MAGIC1 : 8'($urandom);
                end else begin
                    b0 = MAGIC0;
                    do b1 = 8'($urandom); while (b1 == MAGIC1);
                end
                send_word(b0, 1'b1, 1'b1);
                send_word(b1, 1'b0, 1'b1);
                send_junk($urandom_range(0, 4));
            end else if (pick < 87) begin
                case ($urandom_range(2))
                    0: do bpp = 16'($urandom); while (bpp == BPP_24 || bpp == BPP_32);
                    1: w = 32'(MAX_WIDTH + 1) + ($urandom >> $urandom_range(1, 31));
                    default: h = 32'(MAX_HEIGHT + 1) + ($urandom >> $urandom_range(1, 31));
                endcase
                send_header(w, h, bpp, 1'b1, HEADER_BYTES);
                send_junk($urandom_range(0, 4));
            end else if (pick < 91) begin
                // Empty image: nothing comes out and the rest of the file is ignored.
                if ($urandom_range(1)) begin
                    w = 0;
                end else begin
                    h = 0;
                end
                send_header(w, h, bpp, 1'b1, HEADER_BYTES);
                send_junk($urandom_range(0, 6));
            end else if (pick < 95) begin
                // Largest legal width or height, cut after at most 40 pixel bytes.
                if ($urandom_range(1)) begin
                    w = MAX_WIDTH;
                end else begin
                    h = MAX_HEIGHT;
                end
                send_header(w, h, bpp, 1'b1, HEADER_BYTES);
                send_pixels($urandom_range(1, 40), -1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(8'($urandom), 1'($urandom_range(3) == 0), 1'b1);
                end
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ORIGIN_X;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(9, 69);

        // Directed cases run with the origin registers at their reset values.
        // Without any start mark the parser is already at header byte zero after reset;
        // this two-row image pads each row by one byte, and the bytes after its top row
        // are ignored.
        send_image(1, 2, BPP_24, 1'b0, -1);
        send_junk(2);
        // Not a BMP file: first the leading magic byte is wrong, then the second one.
        send_word(8'h41, 1'b1, 1'b1);
        send_word(MAGIC1, 1'b0, 1'b1);
        send_junk(1);
        send_word(MAGIC0, 1'b1, 1'b1);
        send_word(8'h4E, 1'b0, 1'b1);
        // Three pad bytes, with the sender holding off halfway until every result is out,
        // then a 32-bit image carrying alpha.
        send_image(3, 1, BPP_24, 1'b1, 6);
        send_image(2, 1, BPP_32, 1'b1, -1);
        // Unsupported depth, a width with its top bit set, which must be taken as a large
        // unsigned value, and a height just past the limit.
        send_header(2, 2, 16'd16, 1'b1, HEADER_BYTES);
        send_header(32'h8000_0001, 1, BPP_24, 1'b1, HEADER_BYTES);
        send_header(1, MAX_HEIGHT + 1, BPP_32, 1'b1, HEADER_BYTES);
        send_junk(1);
        // An empty image of zero width.
        send_header(0, 3, BPP_24, 1'b1, HEADER_BYTES);
        send_junk(2);
        // A header cut short by a new file, then the largest image, which starts on the
        // highest row and is cut off in the middle of a pixel by the next start mark.
        send_header(5, 5, BPP_24, 1'b1, 20);
        send_header(MAX_WIDTH, MAX_HEIGHT, BPP_32, 1'b1, HEADER_BYTES);
        send_pixels(10, -1);

        // Random phases. Register writes happen only once the block has gone quiet.
        wait_drained();
        set_origins('1, '1);
        run_random(PHASE_BYTES);

        wait_drained();
        set_origins('0, '0);
        set_idling(69, 9);
        run_random(PHASE_BYTES);

        wait_drained();
        set_origins(ORIGIN_W'($urandom), ORIGIN_W'($urandom));
        set_idling(0, 0);
        run_random(PHASE_BYTES);

        wait_drained();
        if (error_count == 0 && results_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
